@@ src/dlpf_pkg.sv @@
`timescale 1ns / 1ps
package dlpf_pkg;

   localparam int MAX_IDS = 16;
   localparam int ID_BITS = 16;
   localparam int SLOT_W  = $clog2(MAX_IDS);
   localparam int CNT_W   = $clog2(MAX_IDS + 1);
   localparam int PROB_W  = 17;
   localparam int SUM_W   = PROB_W + SLOT_W;
   localparam int THR_W   = SUM_W + 1;
   localparam int DIVD_W  = PROB_W + 16;
   localparam int DIVS_W  = SUM_W;

   localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ID_ZERO = 2'd1;
   localparam logic [1:0] ST_WEIGHT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic ACT_OBSERVE = 1'b0;
   localparam logic ACT_QUERY   = 1'b1;

   localparam logic CSR_DECAY    = 1'b0;
   localparam logic CSR_MIN_PROB = 1'b1;

endpackage

@@ src/dlpf_ram.sv @@
`timescale 1ns / 1ps
module dlpf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

@@ src/dlpf_div.sv @@
`timescale 1ns / 1ps
module dlpf_div
   import dlpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIVD_W + 1);

   logic              run_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DIVS_W-1:0] rem_ff;
   logic [DIVD_W-1:0] quo_ff;
   logic [DIVS_W-1:0] dvs_ff;
   logic              done_ff;
   logic [DIVS_W:0]   trial;
   logic              take;

   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign take  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (run_ff) begin
            rem_ff <= take ? DIVS_W'(trial - {1'b0, dvs_ff}) : DIVS_W'(trial);
            quo_ff <= {quo_ff[DIVD_W-2:0], take};
            if (step_ff == STEP_W'(DIVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/decayed_label_probability_fusion.sv @@
`timescale 1ns / 1ps
// Each word is taken while busy is low and answered by a single result word, shown for one
// cycle under rsp_valid; the receiver cannot stall it. Ids and probabilities sit in two
// one-port-read memories that are swept slot by slot. A query or a rejected word is
// answered after an output pass over all slots and the next word is taken after busy falls;
// a word dropped on a full table first runs the whole id search. The first observation
// writes slot 0 directly. Any other observation runs an id search, one or two divisions,
// a blend of each entry, the threshold, a prune of each entry and a division to normalise
// each surviving entry, with empty slots skipped in each pass, and then the output pass.
// The worst case is set mainly by the bit-serial divider that normalises one entry
// at a time.
module decayed_label_probability_fusion
   import dlpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_inst_id,
   input  logic [16:0] req_weight,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_best_id,
   output logic [16:0] rsp_best_prob,
   output logic [16:0] rsp_id_prob,
   output logic        rsp_observed,
   output logic [4:0]  rsp_entry_count,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE, S_FIRST, S_FIND_RD, S_FIND_DO, S_DIV_U, S_DIV_UW, S_DIV_S, S_DIV_SW,
      S_BL_RD, S_BL_MUL, S_BL_WR, S_THR, S_PR_RD, S_PR_DO, S_NM_RD, S_NM_DO,
      S_NM_WAIT, S_OUT_RD, S_OUT_DO, S_DONE
   } state_type;

   state_type          state_ff;
   logic [SLOT_W-1:0]  idx_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               found_ff;
   logic [ID_BITS-1:0] id_ff;
   logic [PROB_W-1:0]  w_ff;
   logic [1:0]         status_ff;
   logic [MAX_IDS-1:0] valid_ff;
   logic [ID_BITS-1:0] best_ff;
   logic [PROB_W-1:0]  bestp_ff;
   logic [PROB_W-1:0]  u_ff;
   logic [PROB_W-1:0]  share_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [SUM_W-1:0]   norm_ff;
   logic [2*PROB_W-1:0] prod_a_ff;
   logic [2*PROB_W-1:0] prod_b_ff;
   logic [ID_BITS-1:0] cur_id_ff;
   logic [PROB_W-1:0]  bprob_ff;
   logic [PROB_W-1:0]  iprob_ff;
   logic               rsp_valid_ff;
   logic [PROB_W-1:0]  decay_ff;
   logic [PROB_W-1:0]  minp_ff;

   logic [CNT_W-1:0]   count;
   logic [SLOT_W-1:0]  free_slot;
   logic [CNT_W-1:0]   share_div;
   logic               last_slot;
   logic [PROB_W-1:0]  dk;
   logic [PROB_W-1:0]  mp;
   logic [ID_BITS-1:0] req_id;

   logic               ids_we;
   logic [SLOT_W-1:0]  ids_waddr;
   logic [ID_BITS-1:0] ids_wdata;
   logic [ID_BITS-1:0] id_rd;
   logic               probs_we;
   logic [SLOT_W-1:0]  probs_waddr;
   logic [PROB_W-1:0]  probs_wdata;
   logic [PROB_W-1:0]  prob_rd;

   logic               div_go;
   logic [DIVD_W-1:0]  div_dividend;
   logic [DIVS_W-1:0]  div_divisor;
   logic               div_done;
   logic [DIVD_W-1:0]  div_quo;

   logic               hit;
   logic [PROB_W-1:0]  bl_old;
   logic [PROB_W-1:0]  bl_tgt;
   logic [2*PROB_W:0]  bl_acc;
   logic [PROB_W-1:0]  bl_new;
   logic [PROB_W+SUM_W-1:0] thr_prod;
   logic [PROB_W-1:0]  nm_q;

   assign req_id = req_inst_id[ID_BITS-1:0];
   assign dk     = (decay_ff > ONE_Q16) ? ONE_Q16 : decay_ff;
   assign mp     = (minp_ff > ONE_Q16) ? ONE_Q16 : minp_ff;
   assign last_slot = idx_ff == SLOT_W'(MAX_IDS - 1);
   assign share_div = found_ff ? count : count + 1'b1;
   assign hit = valid_ff[idx_ff] && (id_rd == id_ff);

   always_comb begin
      count     = '0;
      free_slot = '0;
      for (int i = 0; i < MAX_IDS; i++) begin
         count = count + CNT_W'(valid_ff[i]);
      end
      for (int i = MAX_IDS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign bl_old   = (!found_ff && idx_ff == slot_ff) ? share_ff : prob_rd;
   assign bl_tgt   = (idx_ff == slot_ff) ? w_ff : u_ff;
   assign bl_acc   = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};
   assign bl_new   = bl_acc[PROB_W+15:16];
   assign thr_prod = sum_ff * mp;
   assign nm_q     = div_quo[PROB_W-1:0];

   always_comb begin
      div_go       = 1'b0;
      div_dividend = DIVD_W'(ONE_Q16 - w_ff);
      div_divisor  = DIVS_W'(share_div);
      unique case (state_ff)
         S_DIV_U: div_go = 1'b1;
         S_DIV_S: begin
            div_go       = 1'b1;
            div_dividend = DIVD_W'(ONE_Q16);
         end
         S_NM_DO: begin
            div_go       = norm_ff != '0;
            div_dividend = {prob_rd, 16'b0};
            div_divisor  = norm_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      ids_we      = 1'b0;
      ids_waddr   = slot_ff;
      ids_wdata   = id_ff;
      probs_we    = 1'b0;
      probs_waddr = idx_ff;
      probs_wdata = bl_new;
      unique case (state_ff)
         S_FIRST: begin
            ids_we      = 1'b1;
            ids_waddr   = '0;
            probs_we    = 1'b1;
            probs_waddr = '0;
            probs_wdata = w_ff;
         end
         S_DIV_S:  ids_we = 1'b1;
         S_BL_WR:  probs_we = 1'b1;
         S_NM_DO: begin
            probs_we    = norm_ff == '0;
            probs_wdata = '0;
         end
         S_NM_WAIT: begin
            probs_we    = div_done;
            probs_wdata = nm_q;
         end
         default: ;
      endcase
   end

   dlpf_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_IDS)) u_ids (
      .clock (clock),
      .we    (ids_we),
      .waddr (ids_waddr),
      .wdata (ids_wdata),
      .raddr (idx_ff),
      .rdata (id_rd)
   );

   dlpf_ram #(.WIDTH(PROB_W), .DEPTH(MAX_IDS)) u_probs (
      .clock (clock),
      .we    (probs_we),
      .waddr (probs_waddr),
      .wdata (probs_wdata),
      .raddr (idx_ff),
      .rdata (prob_rd)
   );

   dlpf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         decay_ff     <= PROB_W'(58982);
         minp_ff      <= PROB_W'(655);
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DECAY:    decay_ff <= csr_wdata;
               CSR_MIN_PROB: minp_ff  <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               idx_ff   <= '0;
               found_ff <= 1'b0;
               bprob_ff <= '0;
               iprob_ff <= '0;
               if (start) begin
                  id_ff     <= req_id;
                  w_ff      <= req_weight;
                  status_ff <= ST_OK;
                  if (req_action == ACT_QUERY || req_id == '0) begin
                     status_ff <= (req_id == '0) ? ST_ID_ZERO : ST_OK;
                     state_ff  <= S_OUT_RD;
                  end else if (req_weight > ONE_Q16) begin
                     status_ff <= ST_WEIGHT;
                     state_ff  <= S_OUT_RD;
                  end else if (count == '0) begin
                     state_ff <= S_FIRST;
                  end else begin
                     state_ff <= S_FIND_RD;
                  end
               end
            end
            S_FIRST: begin
               valid_ff[0] <= 1'b1;
               best_ff     <= id_ff;
               state_ff    <= S_OUT_RD;
            end
            S_FIND_RD: state_ff <= S_FIND_DO;
            S_FIND_DO: begin
               if (hit) begin
                  found_ff <= 1'b1;
                  slot_ff  <= idx_ff;
               end
               if (last_slot) begin
                  idx_ff <= '0;
                  if (!(found_ff || hit)) begin
                     slot_ff <= free_slot;
                  end
                  if (!(found_ff || hit) && count == CNT_W'(MAX_IDS)) begin
                     status_ff <= ST_FULL;
                     state_ff  <= S_OUT_RD;
                  end else begin
                     state_ff <= S_DIV_U;
                  end
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_FIND_RD;
               end
            end
            S_DIV_U: state_ff <= S_DIV_UW;
            S_DIV_UW: begin
               sum_ff <= '0;
               if (div_done) begin
                  u_ff     <= nm_q;
                  state_ff <= found_ff ? S_BL_RD : S_DIV_S;
               end
            end
            S_DIV_S: state_ff <= S_DIV_SW;
            S_DIV_SW: begin
               if (div_done) begin
                  share_ff          <= nm_q;
                  valid_ff[slot_ff] <= 1'b1;
                  state_ff          <= S_BL_RD;
               end
            end
            S_BL_RD: begin
               if (valid_ff[idx_ff]) begin
                  state_ff <= S_BL_MUL;
               end else if (last_slot) begin
                  state_ff <= S_THR;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_BL_MUL: begin
               prod_a_ff <= dk * bl_old;
               prod_b_ff <= (ONE_Q16 - dk) * bl_tgt;
               state_ff  <= S_BL_WR;
            end
            S_BL_WR: begin
               sum_ff <= sum_ff + SUM_W'(bl_new);
               if (last_slot) begin
                  state_ff <= S_THR;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_BL_RD;
               end
            end
            S_THR: begin
               thr_ff   <= thr_prod[PROB_W+SUM_W-1:16];
               norm_ff  <= '0;
               idx_ff   <= '0;
               state_ff <= S_PR_RD;
            end
            S_PR_RD: begin
               if (valid_ff[idx_ff]) begin
                  state_ff <= S_PR_DO;
               end else if (last_slot) begin
                  idx_ff   <= '0;
                  bestp_ff <= '0;
                  best_ff  <= '0;
                  state_ff <= S_NM_RD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_PR_DO: begin
               if (THR_W'(prob_rd) < thr_ff) begin
                  valid_ff[idx_ff] <= 1'b0;
               end else begin
                  norm_ff <= norm_ff + SUM_W'(prob_rd);
               end
               if (last_slot) begin
                  idx_ff   <= '0;
                  bestp_ff <= '0;
                  best_ff  <= '0;
                  state_ff <= S_NM_RD;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_PR_RD;
               end
            end
            S_NM_RD: begin
               if (valid_ff[idx_ff]) begin
                  state_ff <= S_NM_DO;
               end else if (last_slot) begin
                  idx_ff   <= '0;
                  state_ff <= S_OUT_RD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_NM_DO: begin
               cur_id_ff <= id_rd;
               if (norm_ff != '0) begin
                  state_ff <= S_NM_WAIT;
               end else if (last_slot) begin
                  idx_ff   <= '0;
                  state_ff <= S_OUT_RD;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_NM_RD;
               end
            end
            S_NM_WAIT: begin
               if (div_done) begin
                  if (nm_q > bestp_ff ||
                      (nm_q == bestp_ff && nm_q != '0 && cur_id_ff < best_ff)) begin
                     bestp_ff <= nm_q;
                     best_ff  <= cur_id_ff;
                  end
                  if (last_slot) begin
                     idx_ff   <= '0;
                     state_ff <= S_OUT_RD;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_NM_RD;
                  end
               end
            end
            S_OUT_RD: state_ff <= S_OUT_DO;
            S_OUT_DO: begin
               if (valid_ff[idx_ff]) begin
                  if (best_ff != '0 && id_rd == best_ff) begin
                     bprob_ff <= prob_rd;
                  end
                  if (id_ff != '0 && id_rd == id_ff) begin
                     iprob_ff <= prob_rd;
                  end
               end
               if (last_slot) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_OUT_RD;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_best_id     = 16'(best_ff);
   assign rsp_best_prob   = bprob_ff;
   assign rsp_id_prob     = iprob_ff;
   assign rsp_observed    = |valid_ff;
   assign rsp_entry_count = 5'(count);

`ifndef ASSERT_OFF
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_busy_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= 5'(MAX_IDS)) else $error("entry count too large");
   a_no_best_prob: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_best_id == '0) |-> rsp_best_prob == '0)
      else $error("probability without a best id");
`endif

endmodule
